@@ hw/rtl/lcst_pkg.sv @@
// ----------------------------------------------------------------------------
// lcst_pkg
// Shared widths, configuration register indexes, datapath operation codes and
// the command/status bundles for the Lab colour statistics transfer block.
// ----------------------------------------------------------------------------
`default_nettype none

package lcst_pkg;

    localparam int MAX_PIXELS     = 16777216;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;
    localparam int PIX_W      = 16;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W      = PIX_W + $clog2(MAX_PIXELS);
    localparam int SUMSQ_W    = 2 * PIX_W + $clog2(MAX_PIXELS);
    localparam int MEAN_FRAC  = 8;
    localparam int MEAN_W     = PIX_W + MEAN_FRAC;
    localparam int MSQ_W      = 2 * MEAN_W;
    localparam int GAIN_W     = 8 + GAIN_FRAC_BITS;
    localparam int RAD_W      = 2 * GAIN_W;
    localparam int REF_SQ_W   = 32;
    localparam int MAP_SH     = MEAN_FRAC + GAIN_FRAC_BITS;

    // Divider: widest dividend of the three divisions, divisor as wide as
    // the source variance
    localparam int DVD_A      = REF_SQ_W + 2 * MEAN_FRAC + 2 * GAIN_FRAC_BITS;
    localparam int DVD_B      = SUMSQ_W + 2 * MEAN_FRAC;
    localparam int DVD_W      = (DVD_A > DVD_B) ? DVD_A : DVD_B;
    localparam int DVS_W      = MSQ_W;
    localparam int DIV_CNT_W  = $clog2(DVD_W);
    localparam int SQ_CNT_W   = $clog2(GAIN_W);

    // Mapping product widths
    localparam int DIFF_W     = MEAN_W + 2;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int MAPT_W     = PROD_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_MEAN_L   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MEAN_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MEAN_B   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_SQMEAN_L = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_SQMEAN_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_SQMEAN_B = 3'd5;

    localparam logic [CH_W-1:0] CH_LAST = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACC,
        OP_DIV_MEAN,
        OP_MEAN_STORE,
        OP_DIV_MSQ,
        OP_MSQ_STORE,
        OP_SQUARES,
        OP_VARS,
        OP_DIV_GAIN,
        OP_SQRT,
        OP_GAIN_STORE,
        OP_ZERO_CH,
        OP_ZERO_GAIN,
        OP_MAP_MUL,
        OP_MAP_ADD,
        OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [CH_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic div_idle;
        logic sqrt_idle;
        logic cnt_zero;
        logic var_ok;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ hw/rtl/lcst_div.sv @@
// ----------------------------------------------------------------------------
// lcst_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcst_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lcst_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [lcst_pkg::DVS_W-1:0]  i_divisor,
    output logic                             o_idle,
    output logic [lcst_pkg::DVD_W-1:0]       o_quot
);

    logic [lcst_pkg::DVD_W-1:0]     r_dvd;
    logic [lcst_pkg::DVS_W-1:0]     r_dsr;
    logic [lcst_pkg::DVS_W-1:0]     r_rem;
    logic [lcst_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic [lcst_pkg::DVS_W:0]       w_trial;
    logic [lcst_pkg::DVS_W:0]       w_diff;
    logic                           w_ge;

    assign w_trial = {r_rem, r_dvd[lcst_pkg::DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == lcst_pkg::DIV_CNT_W'(lcst_pkg::DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // shift the quotient bits in as the dividend bits move out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[lcst_pkg::DVS_W-1:0] : w_trial[lcst_pkg::DVS_W-1:0];
            r_dvd <= {r_dvd[lcst_pkg::DVD_W-2:0], w_ge};
        end
    end

    assign o_idle = !r_busy && !i_start;
    assign o_quot = r_dvd;

endmodule

`default_nettype wire

@@ hw/rtl/lcst_isqrt.sv @@
// ----------------------------------------------------------------------------
// lcst_isqrt
// Integer square root, digit by digit, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcst_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lcst_pkg::RAD_W-1:0]  i_radicand,
    output logic                             o_idle,
    output logic [lcst_pkg::GAIN_W-1:0]      o_root
);

    logic [lcst_pkg::RAD_W-1:0]    r_rad;
    logic [lcst_pkg::GAIN_W+1:0]   r_rem;
    logic [lcst_pkg::GAIN_W-1:0]   r_root;
    logic [lcst_pkg::SQ_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic [lcst_pkg::GAIN_W+3:0]   w_t;
    logic [lcst_pkg::GAIN_W+3:0]   w_trial;
    logic [lcst_pkg::GAIN_W+3:0]   w_diff;
    logic                          w_ge;

    assign w_t     = {r_rem, r_rad[lcst_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);
    assign w_diff  = w_t - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == lcst_pkg::SQ_CNT_W'(lcst_pkg::GAIN_W - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[lcst_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[lcst_pkg::GAIN_W+1:0] : w_t[lcst_pkg::GAIN_W+1:0];
            r_root <= {r_root[lcst_pkg::GAIN_W-2:0], w_ge};
        end
    end

    assign o_idle = !r_busy && !i_start;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ hw/rtl/lcst_dp.sv @@
// ----------------------------------------------------------------------------
// lcst_dp
// Datapath: reference registers, channel sums, derived means and gains,
// shared divider and square root, channel mapping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcst_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_lightness,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_green_red,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_blue_yellow,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_alpha,
    input  wire logic                             i_cfg_write,
    input  wire logic [lcst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lcst_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire lcst_pkg::t_cmd                   i_cmd,
    output lcst_pkg::t_status                     o_status,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_lightness,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_green_red,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_blue_yellow,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_alpha
);

    logic [lcst_pkg::PIX_W-1:0]    r_px      [lcst_pkg::NUM_CH];
    logic [lcst_pkg::PIX_W-1:0]    r_alpha;
    logic [lcst_pkg::PIX_W-1:0]    r_ref_mean[lcst_pkg::NUM_CH];
    logic [lcst_pkg::REF_SQ_W-1:0] r_ref_sq  [lcst_pkg::NUM_CH];
    logic [lcst_pkg::SUM_W-1:0]    r_sum     [lcst_pkg::NUM_CH];
    logic [lcst_pkg::SUMSQ_W-1:0]  r_sumsq   [lcst_pkg::NUM_CH];
    logic [lcst_pkg::CNT_W-1:0]    r_cnt;
    logic [lcst_pkg::MEAN_W-1:0]   r_mean    [lcst_pkg::NUM_CH];
    logic [lcst_pkg::GAIN_W-1:0]   r_gain    [lcst_pkg::NUM_CH];
    logic [lcst_pkg::MSQ_W-1:0]    r_msq;
    logic [lcst_pkg::MSQ_W-1:0]    r_meansq;
    logic [lcst_pkg::REF_SQ_W-1:0] r_refsq;
    logic [lcst_pkg::DVS_W-1:0]    r_vs;
    logic [lcst_pkg::REF_SQ_W-1:0] r_vr;
    logic                          r_var_ok;
    logic                          r_quot_big;
    logic signed [lcst_pkg::PROD_W-1:0] r_prod;
    logic [lcst_pkg::PIX_W-1:0]    r_res     [lcst_pkg::NUM_CH];
    logic                          r_out_valid;
    logic [lcst_pkg::PIX_W-1:0]    r_out     [lcst_pkg::NUM_CH];
    logic [lcst_pkg::PIX_W-1:0]    r_out_alpha;

    logic                          w_full;
    logic [lcst_pkg::PIX_W-1:0]    w_px;
    logic [2*lcst_pkg::PIX_W-1:0]  w_px_sq;
    logic                          w_div_start;
    logic [lcst_pkg::DVD_W-1:0]    w_dividend;
    logic [lcst_pkg::DVS_W-1:0]    w_divisor;
    logic                          w_div_idle;
    logic [lcst_pkg::DVD_W-1:0]    w_quot;
    logic                          w_sqrt_start;
    logic                          w_sqrt_idle;
    logic [lcst_pkg::GAIN_W-1:0]   w_root;
    logic [lcst_pkg::MSQ_W:0]      w_vs;
    logic [lcst_pkg::REF_SQ_W:0]   w_vr;
    logic signed [lcst_pkg::DIFF_W-1:0]  w_diff;
    logic signed [lcst_pkg::GAIN_W:0]    w_gain_s;
    logic signed [lcst_pkg::MAPT_W-1:0]  w_t;
    logic [lcst_pkg::MAPT_W-lcst_pkg::MAP_SH-1:0] w_t_hi;
    logic [lcst_pkg::PIX_W-1:0]    w_mapped;

    assign w_full  = (r_cnt == lcst_pkg::CNT_W'(lcst_pkg::MAX_PIXELS));
    assign w_px    = r_px[i_cmd.ch];
    assign w_px_sq = w_px * w_px;

    // divider operand selection
    assign w_div_start = (i_cmd.op == lcst_pkg::OP_DIV_MEAN) ||
                         (i_cmd.op == lcst_pkg::OP_DIV_MSQ)  ||
                         (i_cmd.op == lcst_pkg::OP_DIV_GAIN);

    always_comb begin
        unique case (i_cmd.op)
            lcst_pkg::OP_DIV_GAIN: begin
                w_dividend = lcst_pkg::DVD_W'({r_vr,
                             {(2*lcst_pkg::MEAN_FRAC + 2*lcst_pkg::GAIN_FRAC_BITS){1'b0}}});
                w_divisor  = r_vs;
            end
            lcst_pkg::OP_DIV_MSQ: begin
                w_dividend = lcst_pkg::DVD_W'({r_sumsq[i_cmd.ch],
                             {(2*lcst_pkg::MEAN_FRAC){1'b0}}});
                w_divisor  = lcst_pkg::DVS_W'(r_cnt);
            end
            default: begin
                w_dividend = lcst_pkg::DVD_W'({r_sum[i_cmd.ch], {lcst_pkg::MEAN_FRAC{1'b0}}});
                w_divisor  = lcst_pkg::DVS_W'(r_cnt);
            end
        endcase
    end

    lcst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_idle     (w_div_idle),
        .o_quot     (w_quot)
    );

    assign w_sqrt_start = (i_cmd.op == lcst_pkg::OP_SQRT);

    lcst_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_quot[lcst_pkg::RAD_W-1:0]),
        .o_idle     (w_sqrt_idle),
        .o_root     (w_root)
    );

    // variances, signed by their top bit
    assign w_vs = {1'b0, r_msq} - {1'b0, r_meansq};
    assign w_vr = {1'b0, r_ref_sq[i_cmd.ch]} - {1'b0, r_refsq};

    // mapping: (x - mean) * gain, then fold in the reference mean and clamp
    assign w_diff   = $signed({2'b00, w_px, {lcst_pkg::MEAN_FRAC{1'b0}}}) -
                      $signed({2'b00, r_mean[i_cmd.ch]});
    assign w_gain_s = $signed({1'b0, r_gain[i_cmd.ch]});
    assign w_t      = $signed({r_prod[lcst_pkg::PROD_W-1], r_prod}) +
                      $signed(lcst_pkg::MAPT_W'({r_ref_mean[i_cmd.ch],
                                                {lcst_pkg::MAP_SH{1'b0}}}));
    assign w_t_hi   = w_t[lcst_pkg::MAPT_W-1:lcst_pkg::MAP_SH];

    always_comb begin
        priority if (w_t[lcst_pkg::MAPT_W-1]) begin
            w_mapped = '0;
        end else if (w_t_hi > (lcst_pkg::MAPT_W-lcst_pkg::MAP_SH)'({lcst_pkg::PIX_W{1'b1}})) begin
            w_mapped = '1;
        end else begin
            w_mapped = w_t_hi[lcst_pkg::PIX_W-1:0];
        end
    end

    // state with a reset value: reference defaults, count, sums, means, gains, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mean[0] <= 16'd0;
            r_ref_mean[1] <= 16'd32768;
            r_ref_mean[2] <= 16'd32768;
            r_ref_sq[0]   <= 32'd0;
            r_ref_sq[1]   <= 32'd1073741824;
            r_ref_sq[2]   <= 32'd1073741824;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            for (int c = 0; c < lcst_pkg::NUM_CH; c++) begin
                r_sum[c]   <= '0;
                r_sumsq[c] <= '0;
                r_mean[c]  <= '0;
                r_gain[c]  <= '0;
            end
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    lcst_pkg::CFG_REF_MEAN_L:   r_ref_mean[0] <= i_cfg_data[lcst_pkg::PIX_W-1:0];
                    lcst_pkg::CFG_REF_MEAN_A:   r_ref_mean[1] <= i_cfg_data[lcst_pkg::PIX_W-1:0];
                    lcst_pkg::CFG_REF_MEAN_B:   r_ref_mean[2] <= i_cfg_data[lcst_pkg::PIX_W-1:0];
                    lcst_pkg::CFG_REF_SQMEAN_L: r_ref_sq[0]   <= i_cfg_data;
                    lcst_pkg::CFG_REF_SQMEAN_A: r_ref_sq[1]   <= i_cfg_data;
                    lcst_pkg::CFG_REF_SQMEAN_B: r_ref_sq[2]   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (i_cmd.op)
                lcst_pkg::OP_CLEAR: begin
                    r_cnt <= '0;
                    for (int c = 0; c < lcst_pkg::NUM_CH; c++) begin
                        r_sum[c]   <= '0;
                        r_sumsq[c] <= '0;
                    end
                end
                lcst_pkg::OP_ACC: begin
                    if (!w_full) begin
                        r_sum[i_cmd.ch]   <= r_sum[i_cmd.ch] + lcst_pkg::SUM_W'(w_px);
                        r_sumsq[i_cmd.ch] <= r_sumsq[i_cmd.ch] + lcst_pkg::SUMSQ_W'(w_px_sq);
                        if (i_cmd.ch == lcst_pkg::CH_LAST) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                lcst_pkg::OP_MEAN_STORE: r_mean[i_cmd.ch] <= w_quot[lcst_pkg::MEAN_W-1:0];
                lcst_pkg::OP_ZERO_CH: begin
                    r_mean[i_cmd.ch] <= '0;
                    r_gain[i_cmd.ch] <= '0;
                end
                lcst_pkg::OP_ZERO_GAIN: r_gain[i_cmd.ch] <= '0;
                lcst_pkg::OP_GAIN_STORE: r_gain[i_cmd.ch] <= r_quot_big ? '1 : w_root;
                lcst_pkg::OP_OUT_LOAD: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload and intermediate result registers, not reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px[0] <= i_lightness;
            r_px[1] <= i_green_red;
            r_px[2] <= i_blue_yellow;
            r_alpha <= i_alpha;
        end
        unique case (i_cmd.op)
            lcst_pkg::OP_MSQ_STORE: r_msq <= w_quot[lcst_pkg::MSQ_W-1:0];
            lcst_pkg::OP_SQUARES: begin
                r_meansq <= r_mean[i_cmd.ch] * r_mean[i_cmd.ch];
                r_refsq  <= r_ref_mean[i_cmd.ch] * r_ref_mean[i_cmd.ch];
            end
            lcst_pkg::OP_VARS: begin
                r_vs     <= w_vs[lcst_pkg::DVS_W-1:0];
                r_vr     <= w_vr[lcst_pkg::REF_SQ_W-1:0];
                r_var_ok <= !w_vs[lcst_pkg::MSQ_W] && (w_vs != '0) && !w_vr[lcst_pkg::REF_SQ_W];
            end
            lcst_pkg::OP_SQRT: r_quot_big <= |w_quot[lcst_pkg::DVD_W-1:lcst_pkg::RAD_W];
            lcst_pkg::OP_MAP_MUL: r_prod <= lcst_pkg::PROD_W'(w_diff * w_gain_s);
            lcst_pkg::OP_MAP_ADD: r_res[i_cmd.ch] <= w_mapped;
            lcst_pkg::OP_OUT_LOAD: begin
                r_out[0]    <= r_res[0];
                r_out[1]    <= r_res[1];
                r_out[2]    <= r_res[2];
                r_out_alpha <= r_alpha;
            end
            default: ;
        endcase
    end

    assign o_status.div_idle  = w_div_idle;
    assign o_status.sqrt_idle = w_sqrt_idle;
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.var_ok    = r_var_ok;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_out_lightness   = r_out[0];
    assign o_out_green_red   = r_out[1];
    assign o_out_blue_yellow = r_out[2];
    assign o_out_alpha       = r_out_alpha;

endmodule

`default_nettype wire

@@ hw/rtl/lcst_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcst_ctrl
// Controller: sequences accumulation, gain derivation and channel mapping
// by issuing one registered datapath command per cycle, OP_NONE while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module lcst_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_accept,
    input  wire logic               i_action,
    input  wire logic               i_first,
    input  wire lcst_pkg::t_status  i_status,
    output logic                    o_in_ready,
    output lcst_pkg::t_cmd          o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_D_START,
        S_D_MEAN_W,
        S_D_MSQ,
        S_D_MSQ_W,
        S_D_SQ,
        S_D_VAR,
        S_D_WAIT,
        S_D_CHK,
        S_D_GDIV_W,
        S_D_SQRT_W,
        S_M_MUL,
        S_M_ADD,
        S_M_OUT
    } t_state;

    t_state                   r_state;
    logic [lcst_pkg::CH_W-1:0] r_ch;
    logic                     r_gains_ready;
    lcst_pkg::t_cmd           r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ch          <= '0;
            r_gains_ready <= 1'b0;
            r_cmd.op      <= lcst_pkg::OP_NONE;
            r_cmd.ch      <= '0;
        end else begin
            r_cmd.op <= lcst_pkg::OP_NONE;
            r_cmd.ch <= r_ch;
            unique case (r_state)
                S_IDLE: begin
                    r_ch <= '0;
                    if (i_in_accept) begin
                        if (!i_action) begin
                            r_gains_ready <= 1'b0;
                            if (i_first) begin
                                r_cmd.op <= lcst_pkg::OP_CLEAR;
                            end
                            r_state <= S_ACC;
                        end else begin
                            r_state <= r_gains_ready ? S_M_MUL : S_D_START;
                        end
                    end
                end
                S_ACC: begin
                    r_cmd.op <= lcst_pkg::OP_ACC;
                    if (r_ch == lcst_pkg::CH_LAST) begin
                        r_state <= S_IDLE;
                    end
                    r_ch <= r_ch + 1'b1;
                end
                S_D_START: begin
                    if (i_status.cnt_zero) begin
                        r_cmd.op <= lcst_pkg::OP_ZERO_CH;
                        if (r_ch == lcst_pkg::CH_LAST) begin
                            r_gains_ready <= 1'b1;
                            r_ch          <= '0;
                            r_state       <= S_M_MUL;
                        end else begin
                            r_ch <= r_ch + 1'b1;
                        end
                    end else begin
                        r_cmd.op <= lcst_pkg::OP_DIV_MEAN;
                        r_state  <= S_D_MEAN_W;
                    end
                end
                S_D_MEAN_W: begin
                    if (i_status.div_idle) begin
                        r_cmd.op <= lcst_pkg::OP_MEAN_STORE;
                        r_state  <= S_D_MSQ;
                    end
                end
                S_D_MSQ: begin
                    r_cmd.op <= lcst_pkg::OP_DIV_MSQ;
                    r_state  <= S_D_MSQ_W;
                end
                S_D_MSQ_W: begin
                    if (i_status.div_idle) begin
                        r_cmd.op <= lcst_pkg::OP_MSQ_STORE;
                        r_state  <= S_D_SQ;
                    end
                end
                S_D_SQ: begin
                    r_cmd.op <= lcst_pkg::OP_SQUARES;
                    r_state  <= S_D_VAR;
                end
                S_D_VAR: begin
                    r_cmd.op <= lcst_pkg::OP_VARS;
                    r_state  <= S_D_WAIT;
                end
                S_D_WAIT: begin
                    r_state <= S_D_CHK;
                end
                S_D_CHK: begin
                    if (i_status.var_ok) begin
                        r_cmd.op <= lcst_pkg::OP_DIV_GAIN;
                        r_state  <= S_D_GDIV_W;
                    end else begin
                        r_cmd.op <= lcst_pkg::OP_ZERO_GAIN;
                        if (r_ch == lcst_pkg::CH_LAST) begin
                            r_gains_ready <= 1'b1;
                            r_ch          <= '0;
                            r_state       <= S_M_MUL;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_D_START;
                        end
                    end
                end
                S_D_GDIV_W: begin
                    if (i_status.div_idle) begin
                        r_cmd.op <= lcst_pkg::OP_SQRT;
                        r_state  <= S_D_SQRT_W;
                    end
                end
                S_D_SQRT_W: begin
                    if (i_status.sqrt_idle) begin
                        r_cmd.op <= lcst_pkg::OP_GAIN_STORE;
                        if (r_ch == lcst_pkg::CH_LAST) begin
                            r_gains_ready <= 1'b1;
                            r_ch          <= '0;
                            r_state       <= S_M_MUL;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_D_START;
                        end
                    end
                end
                S_M_MUL: begin
                    r_cmd.op <= lcst_pkg::OP_MAP_MUL;
                    r_state  <= S_M_ADD;
                end
                S_M_ADD: begin
                    r_cmd.op <= lcst_pkg::OP_MAP_ADD;
                    if (r_ch == lcst_pkg::CH_LAST) begin
                        r_state <= S_M_OUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_M_MUL;
                    end
                end
                S_M_OUT: begin
                    if (i_status.out_free) begin
                        r_cmd.op <= lcst_pkg::OP_OUT_LOAD;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = r_cmd;

endmodule

`default_nettype wire

@@ hw/rtl/lab_color_statistics_transfer.sv @@
// ----------------------------------------------------------------------------
// lab_color_statistics_transfer
// Two-pass Lab16 colour statistics transfer: accumulate source statistics,
// then map each pixel onto the configured reference mean and deviation.
// ----------------------------------------------------------------------------
// Send a frame first as accumulate words (action 0, first set on the opening
// word to clear the sums), then as transform words (action 1). Each
// accumulate word gives no output word; each transform word gives one
// output word, the shared multiplier mapping the three channels one after
// another. The first transform word after accumulation also derives the
// source means and gains: per channel up to three passes of the bit-serial
// divider (one bit a cycle over the 80-bit dividend) and, for a valid
// variance, 24 square-root steps. Sums stop growing once 2^24 pixels have
// been counted. The reference registers may be written only while the block
// is idle; they take effect on the next transform word, while the gains stay
// held until the next accumulate word. An output word waiting to be taken
// stalls the block only at the moment its next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_color_statistics_transfer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input words
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_action,
    input  wire logic                             i_first,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_lightness,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_green_red,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_blue_yellow,
    input  wire logic [lcst_pkg::PIX_W-1:0]       i_alpha,
    // output words
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_lightness,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_green_red,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_blue_yellow,
    output logic [lcst_pkg::PIX_W-1:0]            o_out_alpha,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lcst_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lcst_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic              w_in_accept;
    logic              w_cfg_write;
    lcst_pkg::t_cmd    w_cmd;
    lcst_pkg::t_status w_status;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_in_accept = i_in_valid && o_in_ready;

    lcst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_action    (i_action),
        .i_first     (i_first),
        .i_status    (w_status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (w_cmd)
    );

    lcst_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (w_in_accept),
        .i_lightness       (i_lightness),
        .i_green_red       (i_green_red),
        .i_blue_yellow     (i_blue_yellow),
        .i_alpha           (i_alpha),
        .i_cfg_write       (w_cfg_write),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_lightness   (o_out_lightness),
        .o_out_green_red   (o_out_green_red),
        .o_out_blue_yellow (o_out_blue_yellow),
        .o_out_alpha       (o_out_alpha)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lcst_checker.sv @@
// ----------------------------------------------------------------------------
// lcst_port_checks
// Port-level checks on the colour statistics transfer block.
// ----------------------------------------------------------------------------
`default_nettype none

module lcst_port_checks (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_ready,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [lcst_pkg::PIX_W-1:0]       o_out_lightness,
    input wire logic [lcst_pkg::PIX_W-1:0]       o_out_alpha
);

    // hold an offered output word until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped before acceptance");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_lightness) && $stable(o_out_alpha))
        else $error("output word changed while stalled");

    // one word in flight: no back-to-back acceptance
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while previous word still in work");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not quiet after reset");

endmodule

bind lab_color_statistics_transfer lcst_port_checks u_lcst_port_checks (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_out_lightness (o_out_lightness),
    .o_out_alpha     (o_out_alpha)
);

`default_nettype wire
